[design/ccfn_pkg.sv]
package ccfn_pkg;

  localparam int unsigned FACE_W    = 16;
  localparam int unsigned ROW_IDX_W = 4;
  localparam int unsigned LIMIT_W   = 5;
  localparam int unsigned DEG_W     = 5;

  typedef enum logic {
    OP_WRITE_ROW = 1'b0,
    OP_QUERY     = 1'b1
  } op_e;

  typedef struct packed {
    logic wr_row;
    logic start;
    logic scan;
    logic v_inc;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic s_any;
    logic s_done;
    logic v_last;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

[design/ccfn_ctrl.sv]
module ccfn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               op_i,
  output logic               in_ready_o,
  input  ccfn_pkg::status_t  st_i,
  output ccfn_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == 1'(ccfn_pkg::OP_QUERY)) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr_row = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.s_any) begin
          state_d = ST_EMIT;
        end else if (st_i.v_last) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.v_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!st_i.pend_valid || st_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (st_i.s_done) begin
            if (st_i.v_last) begin
              state_d = ST_FINAL;
            end else begin
              cmd_o.v_inc = 1'b1;
              state_d     = ST_SCAN;
            end
          end
        end
      end
      ST_FINAL: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/ccfn_dp.sv]
module ccfn_dp #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ccfn_pkg::cmd_t                     cmd_i,
  output ccfn_pkg::status_t                  st_o,
  input  logic                               cfg_we_i,
  input  logic [ccfn_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  logic [ccfn_pkg::ROW_IDX_W-1:0]     row_index_i,
  input  logic [ccfn_pkg::FACE_W-1:0]        row_bits_i,
  input  logic [ccfn_pkg::FACE_W-1:0]        face_mask_i,
  input  logic [ccfn_pkg::LIMIT_W-1:0]       scan_limit_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ccfn_pkg::FACE_W-1:0]        neighbour_face_o,
  output logic                               sign_negative_o,
  output logic                               neighbour_valid_o,
  output logic                               is_last_o,
  output logic                               face_in_complex_o,
  output logic [ccfn_pkg::DEG_W-1:0]         up_degree_o
);

  localparam int unsigned FW = ccfn_pkg::FACE_W;
  localparam int unsigned LW = ccfn_pkg::LIMIT_W;
  localparam int unsigned DW = ccfn_pkg::DEG_W;
  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam logic [FW-1:0] VMASK  = FW'((32'd1 << MAX_VERTICES) - 32'd1);
  localparam logic [LW-1:0] MAXV   = LW'(MAX_VERTICES);
  localparam logic [IW-1:0] V_LAST = IW'(MAX_VERTICES - 1);

  logic [MAX_VERTICES-1:0] rows_q [MAX_VERTICES];
  logic [LW-1:0] vcount_q;
  logic [FW-1:0] face_q;
  logic [LW-1:0] limit_q;
  logic [LW-1:0] nv_q;
  logic [IW-1:0] v_q;
  logic [DW-1:0] deg_q;
  logic [FW-1:0] sel_q;
  logic          pend_valid_q;
  logic [FW-1:0] pend_face_q;
  logic          pend_sign_q;
  logic          out_valid_q;
  logic [FW-1:0] out_face_q;
  logic          out_sign_q;
  logic          out_nbv_q;
  logic          out_last_q;
  logic          out_clq_q;
  logic [DW-1:0] out_deg_q;

  logic [FW-1:0] v_oh;
  logic [FW-1:0] col;
  logic [FW-1:0] rowv;
  logic [FW-1:0] missing;
  logic          miss_one;
  logic [FW-1:0] joined_set;
  logic          v_out;
  logic [FW-1:0] sel_now;
  logic          up_hit;
  logic [IW-1:0] u_idx;
  logic [FW-1:0] u_oh;
  logic [FW-1:0] rest;
  logic          new_sign;
  logic [FW-1:0] new_face;
  logic          clq;
  logic          out_free;

  assign v_oh = FW'(1) << v_q;
  assign rowv = FW'(rows_q[v_q]);

  always_comb begin
    col = '0;
    for (int m = 0; m < MAX_VERTICES; m++) begin
      col[m] = rows_q[m][v_q];
    end
  end

  // A candidate joins the face minus one member when at most that member misses it.
  assign missing    = face_q & ~col;
  assign miss_one   = (missing != '0) && ((missing & (missing - FW'(1))) == '0);
  assign joined_set = (missing == '0) ? face_q : (miss_one ? missing : '0);
  assign v_out      = ((face_q & v_oh) == '0);
  assign sel_now    = (v_out && (LW'(v_q) < limit_q)) ? (joined_set & ~rowv) : '0;
  assign up_hit     = v_out && (missing == '0) && (LW'(v_q) < nv_q);

  always_comb begin
    u_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (sel_q[i]) begin
        u_idx = IW'(i);
      end
    end
  end

  assign u_oh     = FW'(1) << u_idx;
  assign rest     = sel_q & ~u_oh;
  assign new_face = (face_q & ~u_oh) | v_oh;
  assign new_sign = ~((^(face_q & (u_oh - FW'(1)))) ^ (^(face_q & (v_oh - FW'(1))))
                      ^ (u_idx < v_q));

  always_comb begin
    clq = 1'b1;
    for (int a = 0; a < MAX_VERTICES; a++) begin
      if (face_q[a] && ((face_q & ~FW'(rows_q[a]) & FW'(32'hFFFF << (a + 1))) != '0)) begin
        clq = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign st_o.s_any      = (sel_now != '0);
  assign st_o.s_done     = (rest == '0);
  assign st_o.v_last     = (v_q == V_LAST);
  assign st_o.pend_valid = pend_valid_q;
  assign st_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        rows_q[r] <= '0;
      end
      vcount_q     <= MAXV;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (cmd_i.wr_row && (LW'(row_index_i) < MAXV)) begin
        rows_q[row_index_i[IW-1:0]] <= row_bits_i[MAX_VERTICES-1:0];
      end
      if (cmd_i.start || cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.emit) begin
        pend_valid_q <= 1'b1;
      end
      if ((cmd_i.emit && pend_valid_q) || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      face_q  <= face_mask_i & VMASK;
      limit_q <= (scan_limit_i > MAXV) ? MAXV : scan_limit_i;
      nv_q    <= (vcount_q > MAXV) ? MAXV : vcount_q;
      v_q     <= '0;
      deg_q   <= '0;
    end
    if (cmd_i.scan) begin
      sel_q <= sel_now;
      if (up_hit) begin
        deg_q <= deg_q + DW'(1);
      end
    end
    if (cmd_i.v_inc) begin
      v_q <= v_q + IW'(1);
    end
    if (cmd_i.emit) begin
      sel_q       <= rest;
      pend_face_q <= new_face;
      pend_sign_q <= new_sign;
      if (pend_valid_q) begin
        out_face_q <= pend_face_q;
        out_sign_q <= pend_sign_q;
        out_nbv_q  <= 1'b1;
        out_last_q <= 1'b0;
        out_clq_q  <= 1'b0;
        out_deg_q  <= '0;
      end
    end
    if (cmd_i.finish) begin
      out_face_q <= pend_valid_q ? pend_face_q : '0;
      out_sign_q <= pend_valid_q && pend_sign_q;
      out_nbv_q  <= pend_valid_q;
      out_last_q <= 1'b1;
      out_clq_q  <= clq;
      out_deg_q  <= deg_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign neighbour_face_o  = out_face_q;
  assign sign_negative_o   = out_sign_q;
  assign neighbour_valid_o = out_nbv_q;
  assign is_last_o         = out_last_q;
  assign face_in_complex_o = out_clq_q;
  assign up_degree_o       = out_deg_q;

endmodule

[design/clique_complex_face_neighbours.sv]
// A row write is taken while idle, and the next word can follow it at once. A query visits
// the candidate vertices one per cycle while no neighbour is being emitted, then emits each
// neighbour it finds, and no new word is accepted until the query ends; the single candidate
// scan and the one-word output register bound the query, and a full output stalls the scan.
module clique_complex_face_neighbours #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [3:0]  row_index_i,
  input  logic [15:0] row_bits_i,
  input  logic [15:0] face_mask_i,
  input  logic [4:0]  scan_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] neighbour_face_o,
  output logic        sign_negative_o,
  output logic        neighbour_valid_o,
  output logic        is_last_o,
  output logic        face_in_complex_o,
  output logic [4:0]  up_degree_o
);

  ccfn_pkg::cmd_t    cmd;
  ccfn_pkg::status_t st;

  ccfn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  ccfn_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .row_index_i       (row_index_i),
    .row_bits_i        (row_bits_i),
    .face_mask_i       (face_mask_i),
    .scan_limit_i      (scan_limit_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .neighbour_face_o  (neighbour_face_o),
    .sign_negative_o   (sign_negative_o),
    .neighbour_valid_o (neighbour_valid_o),
    .is_last_o         (is_last_o),
    .face_in_complex_o (face_in_complex_o),
    .up_degree_o       (up_degree_o)
  );

  a_summary_on_last_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_last_o) |-> (!face_in_complex_o && (up_degree_o == 5'd0)))
    else $error("summary fields set on a word that is not the last");

  a_empty_word_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !neighbour_valid_o) |-> (is_last_o && (neighbour_face_o == 16'd0)))
    else $error("empty word is not a final word with a clear face");

  a_degree_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (up_degree_o <= 5'(MAX_VERTICES)))
    else $error("up degree exceeds the vertex count");

endmodule
